@@ rtl/core/eacc_pkg.sv @@
// Shared types, codes and helpers for the end-around-carry checksum engine.
package eacc_pkg;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  localparam logic [1:0] ST_RUNNING   = 2'd0;
  localparam logic [1:0] ST_COMPLETE  = 2'd1;
  localparam logic [1:0] ST_LIMIT     = 2'd2;
  localparam logic [1:0] ST_SPEC_ERR  = 2'd3;

  localparam logic AMODE_24 = 1'b0;

  typedef struct packed {
    logic [31:0] checksum;
    logic [30:0] next_address;
    logic [31:0] remaining_length;
    logic [1:0]  status;
    logic        finished;
  } result_t;

  typedef struct packed {
    logic [31:0] sum;
    logic [30:0] addr;
    logic [31:0] len;
  } step_t;

  function automatic logic [30:0] wrap_addr(input logic [30:0] addr, input logic mode);
    logic [30:0] res;
    begin
      res = (mode == AMODE_24) ? {7'd0, addr[23:0]} : addr;
      return res;
    end
  endfunction

endpackage

@@ rtl/core/end_around_carry_checksum.sv @@
// Top level of the end-around-carry checksum engine with its result buffer.
//
//   channel   direction  handshake               payload
//   in        request    in_valid / in_ready     opcode, initial_sum, start_address,
//                                                operand_length, odd_register_pair, data_word
//   out       result     out_valid / out_ready   checksum, next_address, remaining_length,
//                                                status, finished
//   cfg       write      cfg_write               cfg_data (address_mode)
//
// No register lies inside a request: the add with end-around carry, the address and length
// update and the status decision sit between the request ports and the result register,
// so a new request is taken every cycle unless the skid entry is full.
// Reset (rst, synchronous) leaves the engine idle with sum, address and length at zero
// and address_mode at 31-bit wrap. A two-entry result buffer (output register plus skid)
// keeps in_ready high while one result waits; in_ready drops only when both are full.
module end_around_carry_checksum #(
  parameter int WORD_LIMIT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [31:0] initial_sum,
  input  logic [30:0] start_address,
  input  logic [31:0] operand_length,
  input  logic        odd_register_pair,
  input  logic [31:0] data_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] checksum,
  output logic [30:0] next_address,
  output logic [31:0] remaining_length,
  output logic [1:0]  status,
  output logic        finished
);
  import eacc_pkg::*;

  localparam int WCW = $clog2(WORD_LIMIT + 1);
  localparam logic [WCW-1:0] LIMIT = WCW'(WORD_LIMIT);

  // engine state
  logic           address_mode;
  logic           busy;
  logic [31:0]    sum_acc;
  logic [30:0]    cur_addr;
  logic [31:0]    bytes_left;
  logic [WCW-1:0] words_done;

  logic           busy_next;
  logic [31:0]    sum_acc_next;
  logic [30:0]    cur_addr_next;
  logic [31:0]    bytes_left_next;
  logic [WCW-1:0] words_done_next;

  // result buffer
  result_t res_next;
  result_t out_reg;
  result_t skid_reg;
  logic    skid_valid;

  step_t   step;
  logic    in_fire;
  logic    out_take;
  logic [30:0] start_addr_w;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_take = out_valid && out_ready;

  eacc_step u_step (
    .address_mode (address_mode),
    .sum          (sum_acc),
    .addr         (cur_addr),
    .len          (bytes_left),
    .data_word    (data_word),
    .step         (step)
  );

  // Next state and result for the request at the ports.
  always_comb begin
    busy_next       = busy;
    sum_acc_next    = sum_acc;
    cur_addr_next   = cur_addr;
    bytes_left_next = bytes_left;
    words_done_next = words_done;
    start_addr_w    = wrap_addr(start_address, address_mode);
    res_next.checksum         = sum_acc;
    res_next.next_address     = cur_addr;
    res_next.remaining_length = bytes_left;
    res_next.status           = ST_RUNNING;
    res_next.finished         = 1'b0;

    if (opcode == OP_START) begin
      res_next.checksum         = initial_sum;
      res_next.next_address     = start_addr_w;
      res_next.remaining_length = operand_length;
      if (odd_register_pair) begin
        // specification error: drop the operation, keep the held state
        busy_next         = 1'b0;
        res_next.status   = ST_SPEC_ERR;
        res_next.finished = 1'b1;
      end else begin
        sum_acc_next    = initial_sum;
        cur_addr_next   = start_addr_w;
        bytes_left_next = operand_length;
        words_done_next = '0;
        if (operand_length == 32'd0) begin
          busy_next         = 1'b0;
          res_next.status   = ST_COMPLETE;
          res_next.finished = 1'b1;
        end else begin
          busy_next = 1'b1;
        end
      end
    end else if (busy) begin
      sum_acc_next    = step.sum;
      cur_addr_next   = step.addr;
      bytes_left_next = step.len;
      if (words_done < LIMIT) begin
        words_done_next = words_done + WCW'(1);
      end
      res_next.checksum         = step.sum;
      res_next.next_address     = step.addr;
      res_next.remaining_length = step.len;
      priority if (step.len == 32'd0) begin
        busy_next         = 1'b0;
        res_next.status   = ST_COMPLETE;
        res_next.finished = 1'b1;
      end else if (words_done_next >= LIMIT) begin
        busy_next         = 1'b0;
        res_next.status   = ST_LIMIT;
        res_next.finished = 1'b1;
      end else begin
        busy_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      address_mode <= 1'b1;
      busy         <= 1'b0;
      sum_acc      <= '0;
      cur_addr     <= '0;
      bytes_left   <= '0;
      words_done   <= '0;
    end else begin
      if (cfg_write) begin
        address_mode <= cfg_data;
      end
      if (in_fire) begin
        busy       <= busy_next;
        sum_acc    <= sum_acc_next;
        cur_addr   <= cur_addr_next;
        bytes_left <= bytes_left_next;
        words_done <= words_done_next;
      end
    end
  end

  // Result buffer: output register in front, skid behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      priority if (out_take && skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= in_fire;
      end else if (out_take || !out_valid) begin
        out_valid <= in_fire;
      end else begin
        if (in_fire) begin
          skid_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (out_take && skid_valid) begin
      out_reg <= skid_reg;
      if (in_fire) begin
        skid_reg <= res_next;
      end
    end else if (out_take || !out_valid) begin
      if (in_fire) begin
        out_reg <= res_next;
      end
    end else begin
      if (in_fire) begin
        skid_reg <= res_next;
      end
    end
  end

  assign checksum         = out_reg.checksum;
  assign next_address     = out_reg.next_address;
  assign remaining_length = out_reg.remaining_length;
  assign status           = out_reg.status;
  assign finished         = out_reg.finished;

  // The skid entry is only ever filled behind a waiting output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while the output register is empty");

  // A delivered result is finished exactly when its status is not running.
  a_finish_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (finished == (status != ST_RUNNING)))
    else $error("finished flag disagrees with status");

  // The word counter saturates at the limit.
  a_words_bound: assert property (@(posedge clk) disable iff (rst)
    words_done <= LIMIT)
    else $error("word counter passed the limit");

  // An odd register pair leaves the engine idle.
  a_spec_idle: assert property (@(posedge clk) disable iff (rst)
    (in_fire && opcode == OP_START && odd_register_pair) |=> !busy)
    else $error("engine busy after a specification error");

endmodule

@@ rtl/core/eacc_step.sv @@
// One data word step: byte masking, end-around-carry add, address and length advance.
module eacc_step (
  input  logic                 address_mode,
  input  logic [31:0]          sum,
  input  logic [30:0]          addr,
  input  logic [31:0]          len,
  input  logic [31:0]          data_word,
  output eacc_pkg::step_t      step
);
  import eacc_pkg::*;

  logic [2:0]  take;
  logic [31:0] word;
  logic [32:0] acc;
  logic [30:0] addr_sum;

  always_comb begin
    if (len >= 32'd4) begin
      take = 3'd4;
      word = data_word;
    end else begin
      take = len[2:0];
      unique case (len[1:0])
        2'd1:    word = data_word & 32'hFF00_0000;
        2'd2:    word = data_word & 32'hFFFF_0000;
        2'd3:    word = data_word & 32'hFFFF_FF00;
        default: word = 32'd0;
      endcase
    end
    // fold the carry out of bit 31 back into bit 0
    acc      = {1'b0, sum} + {1'b0, word};
    addr_sum = addr + {28'd0, take};
    step.sum  = acc[31:0] + {31'd0, acc[32]};
    step.addr = wrap_addr(addr_sum, address_mode);
    step.len  = len - {29'd0, take};
  end

endmodule

@@ test/end_around_carry_checksum_tb.sv @@
// Self-checking testbench for the end-around-carry checksum engine.
module end_around_carry_checksum_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import eacc_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int WORD_LIMIT  = 1024;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_IDLE    = 17;
  localparam logic AMODE_31  = 1'b1;

  // One request as it appears on the input ports.
  typedef struct packed {
    logic        opcode;
    logic [31:0] initial_sum;
    logic [30:0] start_address;
    logic [31:0] operand_length;
    logic        odd_pair;
    logic [31:0] data_word;
  } req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cfg_write         = 1'b0;
  logic        cfg_data          = 1'b0;
  logic        in_valid          = 1'b0;
  logic        in_ready;
  logic        opcode            = OP_START;
  logic [31:0] initial_sum       = '0;
  logic [30:0] start_address     = '0;
  logic [31:0] operand_length    = '0;
  logic        odd_register_pair = 1'b0;
  logic [31:0] data_word         = '0;
  logic        out_valid;
  logic        out_ready         = 1'b0;
  logic [31:0] checksum;
  logic [30:0] next_address;
  logic [31:0] remaining_length;
  logic [1:0]  status;
  logic        finished;

  // Requests waiting for the driver, and the results they must produce.
  req_t    pending_reqs[$];
  result_t expected_sums[$];
  req_t    taken_req;

  // Shadow copy of the engine state, advanced on every accepted request.
  logic        eng_mode  = AMODE_31;
  logic [31:0] eng_sum   = '0;
  logic [30:0] eng_addr  = '0;
  logic [31:0] eng_left  = '0;
  int          eng_words = 0;
  logic        eng_busy  = 1'b0;

  int fail_count    = 0;
  int req_issued    = 0;
  int req_accepted  = 0;
  int results_taken = 0;
  int stim_items    = 0;
  int status_seen[4];

  // Idle control for each side; the stimulus process switches these per phase.
  bit tx_idle       = 1'b1;
  bit rx_idle       = 1'b1;
  int tx_gap        = 0;
  int rx_wait       = 0;
  int rx_seen       = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;

  end_around_carry_checksum #(
    .WORD_LIMIT(WORD_LIMIT)
  ) u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .opcode           (opcode),
    .initial_sum      (initial_sum),
    .start_address    (start_address),
    .operand_length   (operand_length),
    .odd_register_pair(odd_register_pair),
    .data_word        (data_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .checksum         (checksum),
    .next_address     (next_address),
    .remaining_length (remaining_length),
    .status           (status),
    .finished         (finished)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Advance the shadow engine by one request and queue the result it owes.
  task automatic sum_step(input req_t r);
    result_t     res;
    logic [30:0] mask;
    logic [31:0] word;
    logic [31:0] take;
    logic [32:0] acc;
    mask = (eng_mode == AMODE_24) ? 31'h00FF_FFFF : 31'h7FFF_FFFF;
    if (r.opcode == OP_START) begin
      if (r.odd_pair) begin
        // Odd register pair: report the operands, drop to idle, keep the rest.
        eng_busy = 1'b0;
        res = '{r.initial_sum, r.start_address & mask, r.operand_length, ST_SPEC_ERR, 1'b1};
      end else begin
        // A start always wins, even over an operation still in progress.
        eng_sum   = r.initial_sum;
        eng_addr  = r.start_address & mask;
        eng_left  = r.operand_length;
        eng_words = 0;
        eng_busy  = (r.operand_length != '0);
        res = '{eng_sum, eng_addr, eng_left, eng_busy ? ST_RUNNING : ST_COMPLETE, !eng_busy};
      end
    end else if (!eng_busy) begin
      // Stray data word: nothing moves, report the held values.
      res = '{eng_sum, eng_addr, eng_left, ST_RUNNING, 1'b0};
    end else begin
      // Use only the leading bytes that are still part of the operand.
      take = (eng_left >= 32'd4) ? 32'd4 : eng_left;
      word = r.data_word & (32'hFFFF_FFFF << (8 * (4 - take)));
      eng_addr = (eng_addr + take[30:0]) & mask;
      eng_left = eng_left - take;
      // Fold the carry out of bit 31 back into bit 0.
      acc = {1'b0, eng_sum} + {1'b0, word};
      eng_sum = acc[31:0] + {31'd0, acc[32]};
      if (eng_words < WORD_LIMIT) eng_words++;
      // Running out of bytes takes precedence over hitting the word limit.
      if (eng_left == '0) begin
        eng_busy = 1'b0;
        res = '{eng_sum, eng_addr, 32'd0, ST_COMPLETE, 1'b1};
      end else if (eng_words >= WORD_LIMIT) begin
        eng_busy = 1'b0;
        res = '{eng_sum, eng_addr, eng_left, ST_LIMIT, 1'b1};
      end else begin
        res = '{eng_sum, eng_addr, eng_left, ST_RUNNING, 1'b0};
      end
    end
    expected_sums.push_back(res);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  function automatic req_t random_req();
    req_t r;
    r.opcode         = 1'($urandom_range(0, 1));
    r.initial_sum    = $urandom;
    r.start_address  = 31'($urandom);
    r.operand_length = $urandom;
    r.odd_pair       = 1'($urandom_range(0, 1));
    r.data_word      = $urandom;
    return r;
  endfunction

  function automatic req_t mk_start(input logic [31:0] sum, input logic [30:0] addr,
                                    input logic [31:0] len, input logic odd);
    req_t r;
    r = random_req();
    r.opcode         = OP_START;
    r.initial_sum    = sum;
    r.start_address  = addr;
    r.operand_length = len;
    r.odd_pair       = odd;
    return r;
  endfunction

  function automatic req_t mk_data(input logic [31:0] word);
    req_t r;
    r = random_req();
    r.opcode    = OP_DATA;
    r.data_word = word;
    return r;
  endfunction

  // Queue one random operation: mostly a start followed by its data words,
  // sometimes cut short, an odd pair, a huge length, or a stray data word.
  task automatic queue_operation();
    req_t        r;
    int unsigned pick;
    int unsigned words;
    pick = $urandom_range(0, 99);
    r = random_req();
    if (pick < 10) begin
      r.opcode = OP_DATA;
      pending_reqs.push_back(r);
      stim_items++;
    end else if (pick < 20) begin
      r.opcode   = OP_START;
      r.odd_pair = 1'b1;
      pending_reqs.push_back(r);
      stim_items++;
    end else begin
      r.opcode   = OP_START;
      r.odd_pair = 1'b0;
      // Push the address toward the top of the wrap range now and then.
      case ($urandom_range(0, 7))
        0:       r.start_address[30:6] = '1;
        1:       r.start_address[23:6] = '1;
        default: ;
      endcase
      if (pick < 28) begin
        words = $urandom_range(1, 12);
      end else if (pick < 32) begin
        r.operand_length = '0;
        words = 0;
      end else begin
        r.operand_length = $urandom_range(1, 48);
        words = (r.operand_length + 3) / 4;
        // Abandon some operations early with the next start.
        if ($urandom_range(0, 9) == 0) words = $urandom_range(0, words - 1);
      end
      pending_reqs.push_back(r);
      stim_items++;
      repeat (words) begin
        pending_reqs.push_back(mk_data($urandom));
        stim_items++;
      end
    end
  endtask

  // Hold until every queued request has been taken and answered.
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || req_accepted != req_issued ||
           expected_sums.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= mode;
    eng_mode   = mode;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Driver: present the next request after a random gap, hold it until taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else if (in_valid && req_accepted != req_issued) begin
      // Hold the request and its payload until the engine takes it.
    end else if (tx_gap > 0) begin
      tx_gap--;
      in_valid <= 1'b0;
    end else if (pending_reqs.size() != 0) begin
      taken_req = pending_reqs.pop_front();
      opcode            <= taken_req.opcode;
      initial_sum       <= taken_req.initial_sum;
      start_address     <= taken_req.start_address;
      operand_length    <= taken_req.operand_length;
      odd_register_pair <= taken_req.odd_pair;
      data_word         <= taken_req.data_word;
      in_valid          <= 1'b1;
      req_issued++;
      tx_gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: stall a random number of cycles after each result, and
  // hold off for a long stretch whenever the stimulus asks for it.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (rx_seen != results_taken) begin
        rx_seen = results_taken;
        rx_wait = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: check the result taken at this edge, then predict for the
  // request taken at this edge. Check first so a same-edge push can't
  // stand in for a missing result.
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_taken++;
        status_seen[status]++;
        if (expected_sums.size() == 0) begin
          $display("%0t ns: result with nothing expected, expected none, actual %h %h %h %h %b",
                   $time, checksum, next_address, remaining_length, status, finished);
          fail_count++;
        end else begin
          want = expected_sums.pop_front();
          compare_field("checksum", want.checksum, checksum);
          compare_field("next_address", {1'b0, want.next_address}, {1'b0, next_address});
          compare_field("remaining_length", want.remaining_length, remaining_length);
          compare_field("status", {30'd0, want.status}, {30'd0, status});
          compare_field("finished", {31'd0, want.finished}, {31'd0, finished});
        end
      end
      if (in_valid && in_ready) begin
        sum_step('{opcode, initial_sum, start_address, operand_length,
                   odd_register_pair, data_word});
        req_accepted++;
      end
    end
  end

  initial begin : stimulus
    int phase;
    int stim_target;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, 31-bit wrap (the reset setting).
    pending_reqs.push_back(mk_data(32'hFFFF_FFFF));                        // data while idle
    pending_reqs.push_back(mk_start(32'hFFFF_FFFF, 31'h7FFF_FFFE, 32'd9, 1'b0));
    pending_reqs.push_back(mk_data(32'hFFFF_FFFF));                        // carry, addr wraps
    pending_reqs.push_back(mk_data(32'h0000_0001));
    pending_reqs.push_back(mk_data(32'hFFFF_FFFF));                        // one byte left
    pending_reqs.push_back(mk_data(32'h1234_5678));                        // idle again
    pending_reqs.push_back(mk_start(32'h0, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1)); // odd pair
    pending_reqs.push_back(mk_start(32'h1234_5678, 31'h0, 32'd0, 1'b0));  // zero length
    pending_reqs.push_back(mk_start(32'h0, 31'h0, 32'hFFFF_FFFF, 1'b0));
    pending_reqs.push_back(mk_data(32'h8000_0000));
    pending_reqs.push_back(mk_start(32'hFFFF_0000, 31'h00FF_FFFF, 32'd2, 1'b0)); // abandon
    pending_reqs.push_back(mk_data(32'hAABB_CCDD));                        // two bytes left
    pending_reqs.push_back(mk_start(32'h1, 31'h5, 32'd3, 1'b0));
    pending_reqs.push_back(mk_data(32'h1122_3344));                        // three bytes left
    wait_idle();

    // Directed part, 24-bit wrap.
    write_mode(AMODE_24);
    pending_reqs.push_back(mk_start(32'h0, 31'h7FFF_FFFF, 32'd8, 1'b0));   // address masked
    pending_reqs.push_back(mk_data(32'h0000_0000));                        // wraps at 24 bits
    pending_reqs.push_back(mk_data(32'hFFFF_FFFF));
    pending_reqs.push_back(mk_start(32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'd0, 1'b1));
    pending_reqs.push_back(mk_data(32'hFFFF_FFFF));
    wait_idle();

    // Word limit: a long operation still has bytes left when the limit is
    // reached and stops early. Hold off the receiver for a long stretch
    // meanwhile so the engine fills up and stalls its input.
    write_mode(AMODE_31);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_requests++;
    pending_reqs.push_back(mk_start($urandom, 31'($urandom),
                                    32'd4097 + $urandom_range(0, 60000), 1'b0));
    repeat (WORD_LIMIT) pending_reqs.push_back(mk_data($urandom));
    pending_reqs.push_back(mk_data($urandom));
    wait_idle();

    // Short random phases over both wrap widths and several idle patterns.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       write_mode(AMODE_24);
        1:       write_mode(AMODE_31);
        default: write_mode(1'($urandom_range(0, 1)));
      endcase
      tx_idle = (phase == 0 || phase == 3);
      rx_idle = (phase != 1);
      // Stall the receiver for a long stretch while the sender keeps going.
      if (phase == 2) hold_requests++;
      stim_target = stim_items + 10;
      while (stim_items < stim_target) queue_operation();
      wait_idle();
    end

    $display("Checked %0d results for %0d requests over both wrap widths and the word limit",
             results_taken, req_accepted);
    $display("Outcomes: running %0d, complete %0d, limit stop %0d, spec error %0d",
             status_seen[ST_RUNNING], status_seen[ST_COMPLETE], status_seen[ST_LIMIT],
             status_seen[ST_SPEC_ERR]);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(1_000_000 * CLK_PERIOD);
    $display("Timeout with %0d results still expected", expected_sums.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ end_around_carry_checksum.f @@
rtl/core/eacc_pkg.sv
rtl/core/eacc_step.sv
rtl/core/end_around_carry_checksum.sv
test/end_around_carry_checksum_tb.sv
